FILE: design/bct_pkg.sv
`default_nettype none
// ============================================================================
// bct_pkg
// Shared types, constants and helpers of the binary contour tracer.
// ============================================================================
package bct_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int COORD_W    = 9;
    localparam int CFG_W      = 9;
    localparam int CFG_ADDR_W = 2;
    localparam int POS_W      = 10;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SINGLE = 2'd2;

    localparam logic [CFG_W-1:0] RST_WIDTH  = 9'd256;
    localparam logic [CFG_W-1:0] RST_HEIGHT = 9'd256;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    typedef logic [1:0] heading_t;

    localparam heading_t HD_EAST  = 2'd0;
    localparam heading_t HD_SOUTH = 2'd1;
    localparam heading_t HD_WEST  = 2'd2;
    localparam heading_t HD_NORTH = 2'd3;

    // Two white probes turn right, a black left probe turns left.
    function automatic heading_t next_heading(heading_t hd, logic left, logic right);
        heading_t r;
        if (!left && !right) begin
            r = hd + 2'd1;
        end else if (left) begin
            r = hd + 2'd3;
        end else begin
            r = hd;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: design/binary_contour_tracer_unit.sv
`default_nettype none
// ============================================================================
// binary_contour_tracer_unit
// Outer contour tracer over a binary image held in on-chip memory.
// ============================================================================
// The input stream carries words with s_tuser selecting a pixel write (0) or
// a request for the next contour point (1). A pixel write returns nothing;
// every request returns exactly one word on the master side. After reset the
// image memory is swept to white, one entry per cycle; s_tready stays low
// during that sweep while register writes are still taken. The first request
// after a reset, a pixel write or a register write builds the start mask, one
// pixel per cycle through the two image read ports. Searching for a start
// pixel reads each mask entry in S_SCAN_RD and checks it in S_SCAN_CK, as the
// mask memory has a registered read. A step along a contour passes S_WALK_RD,
// which issues both probe reads with the mask clear, S_WALK_CK, which takes
// the turn decision, and S_EMIT, which loads the output register. The
// output register lets the next word be taken while a result waits; when the
// receiver stalls, a request finishes its work and then holds until the
// register is free.
// ============================================================================
module binary_contour_tracer_unit
    import bct_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // pixel_x[8:0], pixel_y[17:9], pixel_black[18], zero fill
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // func
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // corner_x[8:0], corner_y[17:9], zero fill
    output logic [M_TDATA_W-1:0]       m_tdata,
    // point_valid[0], all_done[1]
    output logic [M_TUSER_W-1:0]       m_tuser,
    output logic                       m_tlast,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wdata
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0]    LAST_CELL  = AW'(DEPTH - 1);
    localparam logic [AW-1:0]    ROW_STRIDE = AW'(MAX_WIDTH);
    localparam logic [POS_W-1:0] POS_ONE    = POS_W'(1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IN, S_BUILD, S_BDRAIN, S_SCAN_RD, S_SCAN_CK,
        S_WALK_RD, S_WALK_CK, S_EMIT
    } state_t;

    typedef enum logic [2:0] {
        PH_IDLE, PH_SCAN, PH_WALK, PH_CLOSE, PH_DONE
    } phase_t;

    function automatic logic [AW-1:0] cell_addr(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
        logic [POS_W-1:0] xm1;
        logic [POS_W-1:0] ym1;
        xm1 = x - POS_ONE;
        ym1 = y - POS_ONE;
        return AW'(ym1) * ROW_STRIDE + AW'(xm1);
    endfunction

    function automatic logic in_image(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                      logic [POS_W-1:0] w, logic [POS_W-1:0] h);
        return (x != '0) && (y != '0) && (x <= w) && (y <= h);
    endfunction

    state_t             state_reg;
    phase_t             ph_reg;
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic               single_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic [POS_W-1:0]   bx_reg;
    logic [POS_W-1:0]   by_reg;
    logic               bv_reg;
    logic [AW-1:0]      baddr_reg;
    logic               btop_reg;
    logic [POS_W-1:0]   sx_reg;
    logic [POS_W-1:0]   sy_reg;
    logic               closing_reg;
    logic [POS_W-1:0]   walk_x_reg;
    logic [POS_W-1:0]   walk_y_reg;
    logic [POS_W-1:0]   origin_x_reg;
    logic [POS_W-1:0]   origin_y_reg;
    heading_t           heading_reg;
    logic               pl_in_reg;
    logic               pr_in_reg;
    logic [COORD_W-1:0] res_x_reg;
    logic [COORD_W-1:0] res_y_reg;
    logic               res_valid_reg;
    logic               res_end_reg;
    logic               res_done_reg;
    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;
    logic               m_tlast_reg;

    logic               img_mem  [DEPTH];
    logic               mask_mem [DEPTH];
    logic               img_rd0_reg;
    logic               img_rd1_reg;
    logic               mask_rd_reg;

    logic [POS_W-1:0]   used_w;
    logic [POS_W-1:0]   used_h;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic               pb;
    logic               pix_ok;
    logic               s_accept;

    logic [POS_W-1:0]   walk_x_next;
    logic [POS_W-1:0]   walk_y_next;
    logic [POS_W-1:0]   lx;
    logic [POS_W-1:0]   ly;
    logic [POS_W-1:0]   rx;
    logic [POS_W-1:0]   ry;
    logic               clear_hit;
    heading_t           heading_next;

    logic               img_we;
    logic [AW-1:0]      img_waddr;
    logic               img_wdata;
    logic [AW-1:0]      img_raddr0;
    logic [AW-1:0]      img_raddr1;
    logic               mask_we;
    logic [AW-1:0]      mask_waddr;
    logic               mask_wdata;
    logic [AW-1:0]      mask_raddr;

    always_comb begin
        if (width_reg == '0) begin
            used_w = POS_ONE;
        end else if (32'(width_reg) > MAX_WIDTH) begin
            used_w = POS_W'(MAX_WIDTH);
        end else begin
            used_w = POS_W'(width_reg);
        end
        if (height_reg == '0) begin
            used_h = POS_ONE;
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            used_h = POS_W'(MAX_HEIGHT);
        end else begin
            used_h = POS_W'(height_reg);
        end
    end

    assign s_tready = (state_reg == S_IN);
    assign s_accept = s_tvalid && s_tready;
    assign px       = s_tdata[8:0];
    assign py       = s_tdata[17:9];
    assign pb       = s_tdata[18];
    assign pix_ok   = (px != '0) && (py != '0) && (32'(px) <= MAX_WIDTH)
                      && (32'(py) <= MAX_HEIGHT);

    always_comb begin
        walk_x_next = walk_x_reg;
        walk_y_next = walk_y_reg;
        case (heading_reg)
            HD_NORTH: walk_y_next = walk_y_reg - POS_ONE;
            HD_SOUTH: walk_y_next = walk_y_reg + POS_ONE;
            HD_WEST:  walk_x_next = walk_x_reg - POS_ONE;
            default:  walk_x_next = walk_x_reg + POS_ONE;
        endcase
        case (heading_reg)
            HD_NORTH: begin
                lx = walk_x_next;           ly = walk_y_next;
                rx = walk_x_next + POS_ONE; ry = walk_y_next;
            end
            HD_SOUTH: begin
                lx = walk_x_next + POS_ONE; ly = walk_y_next + POS_ONE;
                rx = walk_x_next;           ry = walk_y_next + POS_ONE;
            end
            HD_WEST: begin
                lx = walk_x_next;           ly = walk_y_next + POS_ONE;
                rx = walk_x_next;           ry = walk_y_next;
            end
            default: begin
                lx = walk_x_next + POS_ONE; ly = walk_y_next;
                rx = walk_x_next + POS_ONE; ry = walk_y_next + POS_ONE;
            end
        endcase
    end

    assign clear_hit    = (heading_reg == HD_EAST)
                          && in_image(walk_x_reg + POS_ONE, walk_y_reg + POS_ONE, used_w, used_h);
    assign heading_next = next_heading(heading_reg, pl_in_reg & img_rd0_reg,
                                       pr_in_reg & img_rd1_reg);

    always_comb begin
        img_we    = 1'b0;
        img_waddr = clr_addr_reg;
        img_wdata = 1'b0;
        if (state_reg == S_CLEAR) begin
            img_we = 1'b1;
        end else if (s_accept && (s_tuser == FUNC_PIXEL) && pix_ok) begin
            img_we    = 1'b1;
            img_waddr = cell_addr(POS_W'(px), POS_W'(py));
            img_wdata = pb;
        end
        if (state_reg == S_BUILD) begin
            img_raddr0 = cell_addr(bx_reg + POS_ONE, by_reg + POS_ONE);
            img_raddr1 = (by_reg == '0) ? img_raddr0 : cell_addr(bx_reg + POS_ONE, by_reg);
        end else begin
            img_raddr0 = cell_addr(lx, ly);
            img_raddr1 = cell_addr(rx, ry);
        end
        mask_we    = 1'b0;
        mask_waddr = baddr_reg;
        mask_wdata = img_rd0_reg & ~(img_rd1_reg & ~btop_reg);
        if (bv_reg) begin
            mask_we = 1'b1;
        end else if ((state_reg == S_WALK_RD) && clear_hit) begin
            mask_we    = 1'b1;
            mask_waddr = cell_addr(walk_x_reg + POS_ONE, walk_y_reg + POS_ONE);
            mask_wdata = 1'b0;
        end
        mask_raddr = cell_addr(sx_reg + POS_ONE, sy_reg + POS_ONE);
    end

    always_ff @(posedge aclk) begin
        if (img_we) begin
            img_mem[img_waddr] <= img_wdata;
        end
        img_rd0_reg <= img_mem[img_raddr0];
        img_rd1_reg <= img_mem[img_raddr1];
    end

    always_ff @(posedge aclk) begin
        if (mask_we) begin
            mask_mem[mask_waddr] <= mask_wdata;
        end
        mask_rd_reg <= mask_mem[mask_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            ph_reg       <= PH_IDLE;
            width_reg    <= RST_WIDTH;
            height_reg   <= RST_HEIGHT;
            single_reg   <= 1'b0;
            clr_addr_reg <= '0;
            bv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            bv_reg <= 1'b0;
            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == LAST_CELL) begin
                        state_reg <= S_IN;
                    end
                end
                S_IN: begin
                    if (s_tvalid) begin
                        closing_reg <= 1'b0;
                        if (s_tuser == FUNC_PIXEL) begin
                            ph_reg <= PH_IDLE;
                        end else begin
                            unique case (ph_reg)
                                PH_IDLE: begin
                                    bx_reg    <= '0;
                                    by_reg    <= '0;
                                    state_reg <= S_BUILD;
                                end
                                PH_SCAN:  state_reg <= S_SCAN_RD;
                                PH_WALK:  state_reg <= S_WALK_RD;
                                PH_CLOSE: begin
                                    res_x_reg     <= walk_x_reg[COORD_W-1:0];
                                    res_y_reg     <= walk_y_reg[COORD_W-1:0];
                                    res_valid_reg <= 1'b1;
                                    res_end_reg   <= 1'b1;
                                    if (single_reg) begin
                                        res_done_reg <= 1'b1;
                                        ph_reg       <= PH_DONE;
                                        state_reg    <= S_EMIT;
                                    end else begin
                                        res_done_reg <= 1'b0;
                                        closing_reg  <= 1'b1;
                                        state_reg    <= S_SCAN_RD;
                                    end
                                end
                                default: begin
                                    res_x_reg     <= '0;
                                    res_y_reg     <= '0;
                                    res_valid_reg <= 1'b0;
                                    res_end_reg   <= 1'b0;
                                    res_done_reg  <= 1'b1;
                                    state_reg     <= S_EMIT;
                                end
                            endcase
                        end
                    end
                end
                S_BUILD: begin
                    bv_reg    <= 1'b1;
                    baddr_reg <= img_raddr0;
                    btop_reg  <= (by_reg == '0);
                    if (bx_reg == used_w - POS_ONE) begin
                        bx_reg <= '0;
                        if (by_reg == used_h - POS_ONE) begin
                            state_reg <= S_BDRAIN;
                        end else begin
                            by_reg <= by_reg + POS_ONE;
                        end
                    end else begin
                        bx_reg <= bx_reg + POS_ONE;
                    end
                end
                S_BDRAIN: begin
                    sx_reg    <= '0;
                    sy_reg    <= '0;
                    ph_reg    <= PH_SCAN;
                    state_reg <= S_SCAN_RD;
                end
                S_SCAN_RD: begin
                    if (sy_reg == used_h) begin
                        ph_reg       <= PH_DONE;
                        res_done_reg <= 1'b1;
                        if (!closing_reg) begin
                            res_x_reg     <= '0;
                            res_y_reg     <= '0;
                            res_valid_reg <= 1'b0;
                            res_end_reg   <= 1'b0;
                        end
                        state_reg <= S_EMIT;
                    end else begin
                        state_reg <= S_SCAN_CK;
                    end
                end
                S_SCAN_CK: begin
                    if (mask_rd_reg) begin
                        if (closing_reg) begin
                            ph_reg    <= PH_SCAN;
                            state_reg <= S_EMIT;
                        end else begin
                            origin_x_reg <= sx_reg;
                            origin_y_reg <= sy_reg;
                            walk_x_reg   <= sx_reg;
                            walk_y_reg   <= sy_reg;
                            heading_reg  <= HD_EAST;
                            ph_reg       <= PH_WALK;
                            state_reg    <= S_WALK_RD;
                        end
                    end else begin
                        if (sx_reg == used_w - POS_ONE) begin
                            sx_reg <= '0;
                            sy_reg <= sy_reg + POS_ONE;
                        end else begin
                            sx_reg <= sx_reg + POS_ONE;
                        end
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_WALK_RD: begin
                    res_x_reg     <= walk_x_reg[COORD_W-1:0];
                    res_y_reg     <= walk_y_reg[COORD_W-1:0];
                    res_valid_reg <= 1'b1;
                    res_end_reg   <= 1'b0;
                    res_done_reg  <= 1'b0;
                    walk_x_reg    <= walk_x_next;
                    walk_y_reg    <= walk_y_next;
                    pl_in_reg     <= in_image(lx, ly, used_w, used_h);
                    pr_in_reg     <= in_image(rx, ry, used_w, used_h);
                    state_reg     <= S_WALK_CK;
                end
                S_WALK_CK: begin
                    heading_reg <= heading_next;
                    if ((walk_x_reg == origin_x_reg) && (walk_y_reg == origin_y_reg)
                        && (heading_next == HD_EAST)) begin
                        ph_reg <= PH_CLOSE;
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= M_TDATA_W'({res_y_reg, res_x_reg});
                        m_tuser_reg  <= {res_done_reg, res_valid_reg};
                        m_tlast_reg  <= res_end_reg;
                        state_reg    <= S_IN;
                    end
                end
                default: state_reg <= S_IN;
            endcase
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_WIDTH: begin
                        width_reg <= cfg_wdata;
                        ph_reg    <= PH_IDLE;
                    end
                    REG_HEIGHT: begin
                        height_reg <= cfg_wdata;
                        ph_reg     <= PH_IDLE;
                    end
                    REG_SINGLE: begin
                        single_reg <= cfg_wdata[0];
                        ph_reg     <= PH_IDLE;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // A word without a point always reports that nothing remains.
    a_empty_is_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tuser[1])
        else $error("word without a point does not report all_done");

    // A contour close is always a real point.
    a_end_has_point: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("contour end flagged on a word without a point");

    // A start pixel found by the scan launches a walk eastward from its corner.
    a_start_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN_CK) && mask_rd_reg && !closing_reg
        |=> (state_reg == S_WALK_RD) && (heading_reg == HD_EAST)
            && (walk_x_reg == origin_x_reg) && (walk_y_reg == origin_y_reg))
        else $error("walk did not start at the found start corner");

    // A pending result never overwrites a word the receiver has not taken.
    a_emit_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) && m_tvalid && !m_tready
        |=> (state_reg == S_EMIT) && $stable(m_tdata))
        else $error("output word overwritten while stalled");

endmodule
`default_nettype wire

FILE: test/binary_contour_tracer_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// binary_contour_tracer_unit_tb
// Self-checking stream testbench for the binary contour tracer.
// ============================================================================
// The testbench loads small binary images pixel by pixel and then asks for
// contour points. An internal model of the tracer predicts every point when
// its request word is accepted. Every returned word is checked field by field
// against the oldest prediction. A directed opening covers the largest image,
// the corner pixels, out-of-range writes and the clamped sizes. It is followed
// by random phases with fresh register settings, random pixel content, noise
// writes that restart the tracer, random idling on both sides, and a long
// receiver stall that backs up the input.
// ============================================================================
module binary_contour_tracer_unit_tb;
    import bct_pkg::*;

    localparam int          MW          = DEF_MAX_WIDTH;
    localparam int          MH          = DEF_MAX_HEIGHT;
    localparam int          ITEM_GOAL   = 1100;
    localparam int          HOLD_CYCLES = 400;
    localparam int unsigned LIMIT       = 8000000;

    typedef struct packed {
        logic       func;
        logic [8:0] px;
        logic [8:0] py;
        logic       black;
    } pix_word_t;

    typedef struct packed {
        logic [8:0] corner_x;
        logic [8:0] corner_y;
        logic       point_valid;
        logic       contour_end;
        logic       all_done;
    } corner_t;

    typedef enum logic [2:0] {TR_IDLE, TR_SCAN, TR_WALK, TR_CLOSE, TR_DONE} trace_phase_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    binary_contour_tracer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Tracer model state.
    bit           img_px   [MW*MH];
    bit           start_px [MW*MH];
    logic [8:0]   cfg_w      = 9'd256;
    logic [8:0]   cfg_h      = 9'd256;
    logic         cfg_single = 1'b0;
    int           wx, wy, ox, oy;
    heading_t     hd         = HD_EAST;
    int unsigned  scan_pos   = 0;
    trace_phase_t tr_state   = TR_IDLE;

    pix_word_t    item_q[$];
    corner_t      corner_q[$];

    int           send_idle_pct = 9;
    int           recv_idle_pct = 88;
    logic         rx_hold       = 1'b0;
    event         rx_hold_go;

    int           n_err      = 0;
    int           n_writes   = 0;
    int           n_requests = 0;
    int           n_points   = 0;
    int           n_contours = 0;
    int           n_pushed   = 0;
    int           n_configs  = 0;
    int unsigned  cyc_count  = 0;

    function automatic int used_width();
        if (cfg_w == 0) return 1;
        if (cfg_w > MW) return MW;
        return int'(cfg_w);
    endfunction

    function automatic int used_height();
        if (cfg_h == 0) return 1;
        if (cfg_h > MH) return MH;
        return int'(cfg_h);
    endfunction

    function automatic bit in_view(int x, int y);
        return x >= 1 && y >= 1 && x <= used_width() && y <= used_height();
    endfunction

    function automatic int pix_index(int x, int y);
        return (y - 1) * MW + (x - 1);
    endfunction

    function automatic bit px_black(int x, int y);
        if (!in_view(x, y)) return 1'b0;
        return img_px[pix_index(x, y)];
    endfunction

    function automatic void build_start_mask();
        int x;
        int y;
        for (y = 1; y <= used_height(); y++) begin
            for (x = 1; x <= used_width(); x++) begin
                start_px[pix_index(x, y)] = px_black(x, y) && !px_black(x, y - 1);
            end
        end
    endfunction

    function automatic bit seek_start();
        int unsigned w;
        int unsigned total;
        w     = used_width();
        total = w * used_height();
        while (scan_pos < total) begin
            if (start_px[pix_index(int'(scan_pos % w) + 1, int'(scan_pos / w) + 1)]) return 1'b1;
            scan_pos++;
        end
        return 1'b0;
    endfunction

    function automatic heading_t turn(int x, int y, heading_t h);
        bit lf;
        bit rt;
        case (h)
            HD_NORTH: begin
                lf = px_black(x, y);
                rt = px_black(x + 1, y);
            end
            HD_SOUTH: begin
                lf = px_black(x + 1, y + 1);
                rt = px_black(x, y + 1);
            end
            HD_WEST: begin
                lf = px_black(x, y + 1);
                rt = px_black(x, y);
            end
            default: begin
                lf = px_black(x + 1, y);
                rt = px_black(x + 1, y + 1);
            end
        endcase
        if (lf) return heading_t'(h - 2'd1);
        if (!rt) return heading_t'(h + 2'd1);
        return h;
    endfunction

    function automatic void walk_step();
        if (hd == HD_EAST && in_view(wx + 1, wy + 1)) start_px[pix_index(wx + 1, wy + 1)] = 1'b0;
        case (hd)
            HD_NORTH: wy--;
            HD_SOUTH: wy++;
            HD_WEST:  wx--;
            default:  wx++;
        endcase
        hd = turn(wx, wy, hd);
        if (wx == ox && wy == oy && hd == HD_EAST) tr_state = TR_CLOSE;
    endfunction

    function automatic corner_t next_corner();
        corner_t r;
        r = '0;
        if (tr_state == TR_IDLE) begin
            build_start_mask();
            scan_pos = 0;
            tr_state = TR_SCAN;
        end
        if (tr_state == TR_SCAN) begin
            if (seek_start()) begin
                ox       = int'(scan_pos % used_width());
                oy       = int'(scan_pos / used_width());
                wx       = ox;
                wy       = oy;
                hd       = HD_EAST;
                tr_state = TR_WALK;
            end else begin
                tr_state = TR_DONE;
            end
        end
        case (tr_state)
            TR_WALK: begin
                r.corner_x    = 9'(wx);
                r.corner_y    = 9'(wy);
                r.point_valid = 1'b1;
                walk_step();
            end
            TR_CLOSE: begin
                r.corner_x    = 9'(wx);
                r.corner_y    = 9'(wy);
                r.point_valid = 1'b1;
                r.contour_end = 1'b1;
                if (cfg_single || !seek_start()) begin
                    tr_state   = TR_DONE;
                    r.all_done = 1'b1;
                end else begin
                    tr_state = TR_SCAN;
                end
            end
            default: begin
                r.all_done = 1'b1;
            end
        endcase
        return r;
    endfunction

    function automatic void take_word(pix_word_t w);
        if (w.func == FUNC_PIXEL) begin
            if (w.px >= 1 && w.py >= 1 && w.px <= MW && w.py <= MH) begin
                img_px[pix_index(int'(w.px), int'(w.py))] = w.black;
            end
            tr_state = TR_IDLE;
            n_writes++;
        end else begin
            corner_q.push_back(next_corner());
            n_requests++;
        end
    endfunction

    function automatic void cmp_field(string name, logic [8:0] want, logic [8:0] got);
        if (got !== want) begin
            $error("%s expected %0d got %0d", name, want, got);
            n_err++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                take_word(item_q.pop_front());
            end
            if (!s_tvalid || s_tready) begin
                if (item_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'({item_q[0].black, item_q[0].py, item_q[0].px});
                    s_tuser  <= item_q[0].func;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_check
        corner_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (corner_q.size() == 0) begin
                    $error("result word arrived with no request outstanding");
                    n_err++;
                end else begin
                    want = corner_q.pop_front();
                    cmp_field("corner_x", want.corner_x, m_tdata[8:0]);
                    cmp_field("corner_y", want.corner_y, m_tdata[17:9]);
                    cmp_field("point_valid", 9'(want.point_valid), 9'(m_tuser[0]));
                    cmp_field("contour_end", 9'(want.contour_end), 9'(m_tlast));
                    cmp_field("all_done", 9'(want.all_done), 9'(m_tuser[1]));
                    if (want.point_valid) n_points++;
                    if (want.contour_end) n_contours++;
                end
            end
            m_tready <= !rx_hold && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always begin
        @(rx_hold_go);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    always @(posedge aclk) begin
        cyc_count <= cyc_count + 1;
        if (cyc_count == LIMIT) begin
            $display("[binary_contour_tracer_unit] ERROR");
            $finish;
        end
    end

    task automatic set_reg(input logic [CFG_ADDR_W-1:0] a, input int v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= CFG_W'(v);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (a)
            REG_WIDTH:  cfg_w = 9'(v);
            REG_HEIGHT: cfg_h = 9'(v);
            default:    cfg_single = v[0];
        endcase
        tr_state = TR_IDLE;
        @(negedge aclk);
    endtask

    task automatic push_pixel(input int x, input int y, input bit b);
        item_q.push_back('{FUNC_PIXEL, 9'(x), 9'(y), b});
        n_pushed++;
    endtask

    task automatic push_request();
        item_q.push_back('{FUNC_STEP, 9'd0, 9'd0, 1'b0});
        n_pushed++;
    endtask

    // Mostly pixels in and just beyond the used area, a few outside the store.
    task automatic push_random_pixel(input int ew, input int eh);
        int x;
        int y;
        int pick;
        pick = $urandom_range(0, 19);
        x    = $urandom_range(1, (ew < MW) ? ew + 1 : MW);
        y    = $urandom_range(1, (eh < MH) ? eh + 1 : MH);
        if (pick == 0) x = $urandom_range(0, 1) ? 0 : $urandom_range(MW + 1, 511);
        if (pick == 1) y = $urandom_range(0, 1) ? 0 : $urandom_range(MH + 1, 511);
        if (pick == 2) begin
            x = $urandom_range(0, 511);
            y = $urandom_range(0, 511);
        end
        push_pixel(x, y, $urandom_range(0, 99) < 55);
    endtask

    task automatic drain_results();
        while (item_q.size() != 0 || corner_q.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    initial begin
        int wv;
        int hv;
        int ew;
        int eh;
        int k;
        int nwr;
        int nreq;
        int phase_no;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Largest image with clamped width, both far corners and rejected writes.
        set_reg(REG_WIDTH, 511);
        set_reg(REG_HEIGHT, 256);
        set_reg(REG_SINGLE, 0);
        n_configs++;
        push_pixel(1, 1, 1'b1);
        push_pixel(2, 1, 1'b1);
        push_pixel(256, 256, 1'b1);
        push_pixel(0, 5, 1'b1);
        push_pixel(511, 511, 1'b1);
        for (k = 0; k < 13; k++) push_request();
        drain_results();

        // Zero sizes act as a single pixel; single contour mode.
        set_reg(REG_WIDTH, 0);
        set_reg(REG_HEIGHT, 0);
        set_reg(REG_SINGLE, 1);
        n_configs++;
        push_pixel(2, 1, 1'b0);
        for (k = 0; k < 6; k++) push_request();

        for (phase_no = 0; n_pushed < ITEM_GOAL; phase_no++) begin
            drain_results();
            if (n_pushed < ITEM_GOAL / 3) begin
                send_idle_pct = 9;
                recv_idle_pct = 88;
            end else if (n_pushed < 2 * ITEM_GOAL / 3) begin
                send_idle_pct = 88;
                recv_idle_pct = 9;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ($urandom_range(0, 9))
                0: begin
                    wv = $urandom_range(256, 511);
                    hv = $urandom_range(1, 2);
                end
                1: begin
                    wv = $urandom_range(0, 1);
                    hv = $urandom_range(256, 511);
                end
                default: begin
                    wv = $urandom_range(1, 10);
                    hv = $urandom_range(1, 10);
                end
            endcase
            set_reg(REG_WIDTH, wv);
            set_reg(REG_HEIGHT, hv);
            set_reg(REG_SINGLE, $urandom_range(0, 3) == 0);
            n_configs++;
            ew = (wv == 0) ? 1 : (wv > MW) ? MW : wv;
            eh = (hv == 0) ? 1 : (hv > MH) ? MH : hv;

            nwr = $urandom_range(1, (ew * eh < 40) ? ew * eh + 2 : 40);
            for (k = 0; k < nwr; k++) push_random_pixel(ew, eh);

            if (phase_no % 6 == 2) ->rx_hold_go;
            nreq = $urandom_range(8, 60);
            for (k = 0; k < nreq; k++) begin
                if ($urandom_range(0, 99) < 6) begin
                    push_random_pixel(ew, eh);
                end else begin
                    push_request();
                end
                if ($urandom_range(0, 199) == 0) drain_results();
            end
        end

        drain_results();
        $display("Ran %0d register settings with %0d pixel writes and %0d point requests.",
                 n_configs, n_writes, n_requests);
        $display("Checked %0d corner points closing %0d contours; %0d mismatches.",
                 n_points, n_contours, n_err);
        if (n_err == 0) begin
            $display("[binary_contour_tracer_unit] OK");
        end else begin
            $display("[binary_contour_tracer_unit] ERROR");
        end
        $finish;
    end

endmodule
